// ----- hw/rtl/pcoc_pkg.sv -----
// Shared types and constants for the phase current offset calibrator.
// No dependencies; every other file of the block imports this package.
package pcoc_pkg;

	localparam int SUM_BITS    = 32;
	localparam int OFFSET_BITS = 20;
	localparam int COUNT_BITS  = 16;
	localparam int CMD_BITS    = 2;
	localparam int PHASE_BITS  = 2;
	localparam int CFG_IDX_BITS = 1;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [CMD_BITS-1:0] CMD_SAMPLE = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_START  = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_POLL   = 2'd2;

	localparam logic [PHASE_BITS-1:0] PHASE_IDLE     = 2'd0;
	localparam logic [PHASE_BITS-1:0] PHASE_SKIP     = 2'd1;
	localparam logic [PHASE_BITS-1:0] PHASE_SAMPLING = 2'd2;
	localparam logic [PHASE_BITS-1:0] PHASE_LOCKED   = 2'd3;

	localparam logic [CFG_IDX_BITS-1:0] REG_SKIP_COUNT    = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_AVERAGE_COUNT = 1'd1;

	localparam logic [COUNT_BITS-1:0] SKIP_COUNT_RESET    = 16'd200;
	localparam logic [COUNT_BITS-1:0] AVERAGE_COUNT_RESET = 16'd4000;

	// Commands from the sequencer to each phase lane.
	typedef struct packed {
		logic                  clear;      // start: zero sum and held offset
		logic                  sum_clear;  // end of skip phase: zero sum
		logic                  accum;      // add the sample to the sum
		logic                  div_start;  // lock: divide sum by div_count
		logic [COUNT_BITS-1:0] div_count;
	} lane_ctrl_t;

endpackage

// ----- hw/rtl/pcoc_if.sv -----
// Channel interfaces of the offset calibrator: samples in, status out, and
// the configuration write channel. Depends on pcoc_pkg.
interface pcoc_in_if import pcoc_pkg::*; #(parameter int SAMPLE_BITS = 16);
	logic                           valid;
	logic                           ready;
	logic [CMD_BITS-1:0]            cmd;
	logic signed [SAMPLE_BITS-1:0]  current_u_ma;
	logic signed [SAMPLE_BITS-1:0]  current_v_ma;
	logic signed [SAMPLE_BITS-1:0]  current_w_ma;

	modport source (output valid, cmd, current_u_ma, current_v_ma, current_w_ma, input ready);
	modport sink (input valid, cmd, current_u_ma, current_v_ma, current_w_ma, output ready);
endinterface

interface pcoc_out_if import pcoc_pkg::*;;
	logic                           valid;
	logic                           ready;
	logic                           feed_done;
	logic [PHASE_BITS-1:0]          calib_phase;
	logic signed [OFFSET_BITS-1:0]  offset_u;
	logic signed [OFFSET_BITS-1:0]  offset_v;
	logic signed [OFFSET_BITS-1:0]  offset_w;

	modport source (output valid, feed_done, calib_phase, offset_u, offset_v, offset_w,
		input ready);
	modport sink (input valid, feed_done, calib_phase, offset_u, offset_v, offset_w,
		output ready);
endinterface

interface pcoc_cfg_if import pcoc_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic [CFG_IDX_BITS-1:0]   index;
	logic [CFG_DATA_BITS-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/pcoc_lane.sv -----
// One phase lane: sample accumulator, restoring divider (one quotient bit
// per cycle) and the saturated held offset. Depends on pcoc_pkg.
module pcoc_lane import pcoc_pkg::*; #(
	parameter int SAMPLE_BITS   = 16,
	parameter int FRACTION_BITS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lane_ctrl_t                    ctrl,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          done,
	output logic signed [OFFSET_BITS-1:0] offset
);

	localparam int QW        = SUM_BITS + FRACTION_BITS;
	localparam int STEP_BITS = $clog2(QW);
	localparam logic [QW-1:0] LIM_POS = QW'((64'd1 << (OFFSET_BITS - 1)) - 64'd1);
	localparam logic [QW-1:0] LIM_NEG = QW'(64'd1 << (OFFSET_BITS - 1));

	typedef enum logic [1:0] {L_IDLE, L_LOAD, L_ITER, L_FIN} lane_state_t;

	lane_state_t              state_q;
	logic [SUM_BITS-1:0]      sum_q;
	logic [OFFSET_BITS-1:0]   held_q;
	logic                     done_q;
	logic [COUNT_BITS-1:0]    dvs_q;
	logic [QW-1:0]            dvd_q;
	logic [COUNT_BITS-1:0]    rem_q;
	logic                     neg_q;
	logic [STEP_BITS-1:0]     step_q;

	logic [SUM_BITS-1:0]      sample_ext;
	logic [SUM_BITS-1:0]      mag;
	logic [COUNT_BITS:0]      rem_sh;
	logic [COUNT_BITS:0]      rem_diff;
	logic                     ge;
	logic [QW-1:0]            q_sat;
	logic [OFFSET_BITS-1:0]   q_res;

	assign sample_ext = {{(SUM_BITS - SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
	// The most negative sum negates to itself, which read unsigned is its magnitude.
	assign mag = sum_q[SUM_BITS-1] ? (~sum_q + 1'b1) : sum_q;

	assign rem_sh   = {rem_q, dvd_q[QW-1]};
	assign rem_diff = rem_sh - {1'b0, dvs_q};
	assign ge       = (rem_sh >= {1'b0, dvs_q});

	always_comb begin
		if (neg_q) begin
			q_sat = (dvd_q > LIM_NEG) ? LIM_NEG : dvd_q;
			q_res = OFFSET_BITS'(~q_sat + 1'b1);
		end else begin
			q_sat = (dvd_q > LIM_POS) ? LIM_POS : dvd_q;
			q_res = q_sat[OFFSET_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			sum_q   <= '0;
			held_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == L_FIN);
			if (ctrl.clear) begin
				sum_q  <= '0;
				held_q <= '0;
			end else if (ctrl.sum_clear) begin
				sum_q <= '0;
			end else if (ctrl.accum) begin
				sum_q <= sum_q + sample_ext;
			end
			unique case (state_q)
				L_IDLE: begin
					if (ctrl.div_start) begin
						dvs_q   <= (ctrl.div_count == '0) ? COUNT_BITS'(1) : ctrl.div_count;
						state_q <= L_LOAD;
					end
				end
				L_LOAD: begin
					dvd_q   <= QW'(mag) << FRACTION_BITS;
					neg_q   <= sum_q[SUM_BITS-1];
					rem_q   <= '0;
					step_q  <= '0;
					state_q <= L_ITER;
				end
				L_ITER: begin
					dvd_q  <= {dvd_q[QW-2:0], ge};
					rem_q  <= ge ? rem_diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
					step_q <= step_q + 1'b1;
					if (step_q == STEP_BITS'(QW - 1)) begin
						state_q <= L_FIN;
					end
				end
				L_FIN: begin
					held_q  <= q_res;
					state_q <= L_IDLE;
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign offset = held_q;

endmodule

// ----- hw/rtl/phase_current_offset_calibrator_unit.sv -----
// Phase current offset calibrator, top level: command sequencer, three phase
// lanes and the merge of their results. Depends on pcoc_pkg, pcoc_if, pcoc_lane.
// The result of every item but the one that locks is shown the cycle after
// acceptance; the locking item waits for each lane's bit-serial divider to load,
// iterate and finish. One item is in flight at a time, so one item per cycle is
// accepted while the output is empty or taken; the locking item holds further input.
// Reset (arst_n, asynchronous) gives phase idle, zero sums and offsets, and
// skip_count 200, average_count 4000.
module phase_current_offset_calibrator_unit import pcoc_pkg::*; #(
	parameter int SAMPLE_BITS   = 16,
	parameter int FRACTION_BITS = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	pcoc_in_if.sink        sample_in,
	pcoc_out_if.source     result_out,
	pcoc_cfg_if.sink       cfg
);

	typedef enum logic {ST_READY, ST_DIV} seq_state_t;

	seq_state_t             state_q;
	logic [PHASE_BITS-1:0]  mode_q;
	logic [COUNT_BITS-1:0]  count_q;
	logic [COUNT_BITS-1:0]  skip_count_q;
	logic [COUNT_BITS-1:0]  average_count_q;
	logic                   out_valid_q;
	logic                   feed_done_q;

	lane_ctrl_t             ctrl;
	logic [COUNT_BITS-1:0]  count_inc;
	logic                   in_fire;
	logic                   out_fire;
	logic                   locking;
	logic [2:0]             lane_done;
	logic signed [OFFSET_BITS-1:0] off_u, off_v, off_w;

	assign sample_in.ready = (state_q == ST_READY) && (!out_valid_q || result_out.ready);
	assign in_fire   = sample_in.valid && sample_in.ready;
	assign out_fire  = result_out.valid && result_out.ready;
	assign count_inc = count_q + 1'b1;
	assign cfg.ready = 1'b1;

	always_comb begin
		ctrl = '0;
		ctrl.div_count = count_inc;
		locking = 1'b0;
		if (in_fire) begin
			case (sample_in.cmd)
				CMD_START: ctrl.clear = 1'b1;
				CMD_SAMPLE: begin
					if (mode_q == PHASE_SKIP) begin
						ctrl.sum_clear = (count_inc >= skip_count_q);
					end else if (mode_q == PHASE_SAMPLING) begin
						ctrl.accum     = 1'b1;
						locking        = (count_inc >= average_count_q);
						ctrl.div_start = locking;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_count_q    <= SKIP_COUNT_RESET;
			average_count_q <= AVERAGE_COUNT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SKIP_COUNT:    skip_count_q    <= cfg.data;
				REG_AVERAGE_COUNT: average_count_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_READY;
			mode_q      <= PHASE_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			feed_done_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_READY: begin
					if (in_fire) begin
						feed_done_q <= (mode_q == PHASE_LOCKED);
						if (sample_in.cmd == CMD_START) begin
							mode_q  <= PHASE_SKIP;
							count_q <= '0;
						end else if (sample_in.cmd == CMD_SAMPLE) begin
							if (mode_q == PHASE_SKIP) begin
								if (ctrl.sum_clear) begin
									count_q <= '0;
									mode_q  <= PHASE_SAMPLING;
								end else begin
									count_q <= count_inc;
								end
							end else if (mode_q == PHASE_SAMPLING) begin
								count_q <= count_inc;
								if (locking) begin
									mode_q <= PHASE_LOCKED;
								end
							end
						end
						if (locking) begin
							state_q     <= ST_DIV;
							out_valid_q <= 1'b0;
						end else begin
							out_valid_q <= 1'b1;
						end
					end else if (out_fire) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_DIV: begin
					// The lanes run in lockstep; the result waits for all three.
					if (&lane_done) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_READY;
					end
				end
				default: state_q <= ST_READY;
			endcase
		end
	end

	pcoc_lane #(.SAMPLE_BITS(SAMPLE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_lane_u (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .sample(sample_in.current_u_ma),
		.done(lane_done[0]), .offset(off_u)
	);

	pcoc_lane #(.SAMPLE_BITS(SAMPLE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_lane_v (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .sample(sample_in.current_v_ma),
		.done(lane_done[1]), .offset(off_v)
	);

	pcoc_lane #(.SAMPLE_BITS(SAMPLE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_lane_w (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .sample(sample_in.current_w_ma),
		.done(lane_done[2]), .offset(off_w)
	);

	// Phase and offsets change only on an accepted transaction or at the end of
	// a divide, never while a result waits, so they feed the output directly.
	assign result_out.valid       = out_valid_q;
	assign result_out.feed_done   = feed_done_q;
	assign result_out.calib_phase = mode_q;
	assign result_out.offset_u    = off_u;
	assign result_out.offset_v    = off_v;
	assign result_out.offset_w    = off_w;

endmodule
